// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/illm_pkg.sv =====
// Shared types and codes of the indexed linked list manager.
package illm_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int MODE_W    = 2;
    localparam int SLOT_FW   = 4;
    localparam int STAT_W    = 2;
    localparam int COUNT_FW  = 5;

    localparam logic [MODE_W-1:0] MODE_AFTER  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEFORE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SLOT_FW-1:0] slot;
    } t_item;

    typedef struct packed {
        logic [SLOT_FW-1:0]  result_slot;
        logic [STAT_W-1:0]   status;
        logic [SLOT_FW-1:0]  head_slot;
        logic [SLOT_FW-1:0]  tail_slot;
        logic [COUNT_FW-1:0] count;
        logic                is_empty;
    } t_result;

endpackage

// ===== design/illm_if.sv =====
// Handshake channels of the indexed linked list manager.
interface illm_in_if;
    logic                             valid;
    logic                             ready;
    logic [illm_pkg::MODE_W-1:0]      mode;
    logic [illm_pkg::SLOT_FW-1:0]     slot;

    modport source(output valid, mode, slot, input ready);
    modport sink(input valid, mode, slot, output ready);
endinterface

interface illm_out_if;
    logic                             valid;
    logic                             ready;
    logic [illm_pkg::SLOT_FW-1:0]     result_slot;
    logic [illm_pkg::STAT_W-1:0]      status;
    logic [illm_pkg::SLOT_FW-1:0]     head_slot;
    logic [illm_pkg::SLOT_FW-1:0]     tail_slot;
    logic [illm_pkg::COUNT_FW-1:0]    count;
    logic                             is_empty;

    modport source(output valid, result_slot, status, head_slot, tail_slot, count, is_empty,
                   input ready);
    modport sink(input valid, result_slot, status, head_slot, tail_slot, count, is_empty,
                 output ready);
endinterface

// ===== design/illm_update.sv =====
// Next-state and result logic for one list operation.
module illm_update #(
    parameter int  SLOTS  = illm_pkg::SLOTS_DEF,
    localparam int SLOT_W = $clog2(SLOTS),
    localparam int LINK_W = $clog2(SLOTS + 1)
) (
    input  illm_pkg::t_item    i_item,
    input  logic [LINK_W-1:0]  i_next [SLOTS],
    input  logic [LINK_W-1:0]  i_prev [SLOTS],
    input  logic [LINK_W-1:0]  i_free_head,
    input  logic [SLOT_W-1:0]  i_head,
    input  logic [SLOT_W-1:0]  i_tail,
    input  logic [LINK_W-1:0]  i_count,
    output logic [LINK_W-1:0]  o_next [SLOTS],
    output logic [LINK_W-1:0]  o_prev [SLOTS],
    output logic [LINK_W-1:0]  o_free_head,
    output logic [SLOT_W-1:0]  o_head,
    output logic [SLOT_W-1:0]  o_tail,
    output logic [LINK_W-1:0]  o_count,
    output illm_pkg::t_result  o_result
);

    localparam int CMP_W = ((LINK_W > illm_pkg::SLOT_FW) ? LINK_W : illm_pkg::SLOT_FW) + 1;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    logic [CMP_W-1:0]  ref_x;
    logic [CMP_W-1:0]  cnt_x;
    logic [SLOT_W-1:0] ref_idx;
    logic              ref_in_table;
    logic              ins_ref_ok;
    logic [SLOT_W-1:0] c;
    logic [LINK_W-1:0] nn;
    logic [LINK_W-1:0] pp;
    logic [CMP_W-1:0]  new_cnt_x;

    // A link at or above the slot count stands for "no slot".
    function automatic logic is_slot(input logic [LINK_W-1:0] x);
        return x < NIL;
    endfunction

    function automatic logic [illm_pkg::SLOT_FW-1:0] to_field(input logic [SLOT_W-1:0] x);
        logic [CMP_W-1:0] w;
        w = CMP_W'(x);
        return w[illm_pkg::SLOT_FW-1:0];
    endfunction

    assign ref_x        = CMP_W'(i_item.slot);
    assign cnt_x        = CMP_W'(i_count);
    assign ref_idx      = ref_x[SLOT_W-1:0];
    assign ref_in_table = ref_x < CMP_W'(SLOTS);
    assign ins_ref_ok   = ref_in_table && (ref_x <= cnt_x);

    // The table writes below follow one another in order, so later reads
    // see earlier writes of the same operation, even when slots alias.
    always_comb begin
        o_next               = i_next;
        o_prev               = i_prev;
        o_free_head          = i_free_head;
        o_head               = i_head;
        o_tail               = i_tail;
        o_count              = i_count;
        o_result.result_slot = '0;
        o_result.status      = illm_pkg::ST_OK;
        c                    = '0;
        nn                   = '0;
        pp                   = '0;

        case (i_item.mode)
            illm_pkg::MODE_AFTER, illm_pkg::MODE_BEFORE: begin
                if (!ins_ref_ok) begin
                    o_result.status = illm_pkg::ST_BAD;
                end else if (cnt_x >= CMP_W'(SLOTS)) begin
                    o_result.status = illm_pkg::ST_FULL;
                end else begin
                    // Reuse a freed slot first, else the next never-used one.
                    if (is_slot(i_free_head)) begin
                        c           = i_free_head[SLOT_W-1:0];
                        o_free_head = i_next[c];
                    end else if (is_slot(i_count)) begin
                        c = i_count[SLOT_W-1:0];
                    end
                    o_next[c] = NIL;
                    o_prev[c] = NIL;
                    if (i_count == '0) begin
                        o_head = c;
                        o_tail = c;
                    end else if (i_item.mode == illm_pkg::MODE_AFTER) begin
                        nn        = o_next[ref_idx];
                        o_prev[c] = LINK_W'(ref_idx);
                        if (is_slot(nn)) begin
                            o_prev[nn[SLOT_W-1:0]] = LINK_W'(c);
                            o_next[c]              = nn;
                        end
                        o_next[ref_idx] = LINK_W'(c);
                        if (!is_slot(o_next[c])) begin
                            o_tail = c;
                        end
                    end else begin
                        pp        = o_prev[ref_idx];
                        o_next[c] = LINK_W'(ref_idx);
                        if (is_slot(pp)) begin
                            o_prev[c]              = pp;
                            o_next[pp[SLOT_W-1:0]] = LINK_W'(c);
                        end
                        o_prev[ref_idx] = LINK_W'(c);
                        if (!is_slot(o_prev[c])) begin
                            o_head = c;
                        end
                    end
                    o_count              = i_count + LINK_W'(1);
                    o_result.result_slot = to_field(c);
                end
            end
            illm_pkg::MODE_REMOVE: begin
                if (!ref_in_table || i_count == '0) begin
                    o_result.status = illm_pkg::ST_BAD;
                end else begin
                    nn = i_next[ref_idx];
                    pp = i_prev[ref_idx];
                    if (is_slot(nn)) begin
                        o_prev[nn[SLOT_W-1:0]] = pp;
                        if (ref_idx == i_head) begin
                            o_head = nn[SLOT_W-1:0];
                        end
                    end
                    if (is_slot(pp)) begin
                        o_next[pp[SLOT_W-1:0]] = nn;
                        if (ref_idx == i_tail) begin
                            o_tail = pp[SLOT_W-1:0];
                        end
                    end
                    o_next[ref_idx]      = i_free_head;
                    o_free_head          = LINK_W'(ref_idx);
                    o_count              = i_count - LINK_W'(1);
                    o_result.result_slot = to_field(ref_idx);
                end
            end
            default: begin
                o_result.status = illm_pkg::ST_BAD;
            end
        endcase

        new_cnt_x          = CMP_W'(o_count);
        o_result.is_empty  = (o_count == '0);
        o_result.head_slot = o_result.is_empty ? '0 : to_field(o_head);
        o_result.tail_slot = o_result.is_empty ? '0 : to_field(o_tail);
        o_result.count     = new_cnt_x[illm_pkg::COUNT_FW-1:0];
    end

endmodule

// ===== design/indexed_linked_list_manager.sv =====
// Indexed doubly linked list manager: top level with handshake and state registers.
//
// Usage: items arrive on i_in (mode, slot) and each one gives exactly one
// result item on o_out (result_slot, status, head_slot, tail_slot, count,
// is_empty). Mode 0 inserts a new slot after the given slot, mode 1 before
// it, and mode 2 removes the given slot; new slots come from the free list
// first. An accepted item waits in the input register until the result
// register is free or drains, and its result is then written there; one
// item per cycle is sustained while o_out.ready stays high, since the
// whole operation is a single pass of update logic over the link tables,
// which are held in registers and read and written in the same cycle.
// The input register and the result register each hold one item; while the
// receiver stalls, the input register still takes one more item and then
// i_in.ready falls until o_out is drained.
// Reset (i_rst_n low at a clock edge) empties the list and the free list and
// drops any item in flight. The link tables are not cleared; the list
// logic never reads an entry before writing it in normal use.
module indexed_linked_list_manager #(
    parameter int SLOTS = illm_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    illm_in_if.sink           i_in,
    illm_out_if.source        o_out
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    logic [LINK_W-1:0] r_next [SLOTS];
    logic [LINK_W-1:0] r_prev [SLOTS];
    logic [LINK_W-1:0] n_next [SLOTS];
    logic [LINK_W-1:0] n_prev [SLOTS];
    logic [LINK_W-1:0] r_free_head, n_free_head;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [LINK_W-1:0] r_count, n_count;

    logic              r_in_valid;
    illm_pkg::t_item   r_item;
    logic              r_out_valid;
    illm_pkg::t_result r_result;
    illm_pkg::t_result n_result;

    logic advance;

    // The stored item moves on when the result register is free or drains now.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    illm_update #(
        .SLOTS(SLOTS)
    ) u_update (
        .i_item      (r_item),
        .i_next      (r_next),
        .i_prev      (r_prev),
        .i_free_head (r_free_head),
        .i_head      (r_head),
        .i_tail      (r_tail),
        .i_count     (r_count),
        .o_next      (n_next),
        .o_prev      (n_prev),
        .o_free_head (n_free_head),
        .o_head      (n_head),
        .o_tail      (n_tail),
        .o_count     (n_count),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_free_head <= NIL;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_free_head <= n_free_head;
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.mode <= i_in.mode;
            r_item.slot <= i_in.slot;
        end
        if (advance) begin
            r_result <= n_result;
            r_next   <= n_next;
            r_prev   <= n_prev;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_slot = r_result.result_slot;
    assign o_out.status      = r_result.status;
    assign o_out.head_slot   = r_result.head_slot;
    assign o_out.tail_slot   = r_result.tail_slot;
    assign o_out.count       = r_result.count;
    assign o_out.is_empty    = r_result.is_empty;

endmodule

// ===== design/illm_checker.sv =====
// Port-level checker for the indexed linked list manager, bound to the top level.
`include "assert_macros.svh"

module illm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [illm_pkg::SLOT_FW-1:0]    i_result_slot,
    input logic [illm_pkg::STAT_W-1:0]     i_status,
    input logic [illm_pkg::SLOT_FW-1:0]    i_head_slot,
    input logic [illm_pkg::SLOT_FW-1:0]    i_tail_slot,
    input logic [illm_pkg::COUNT_FW-1:0]   i_count,
    input logic                            i_is_empty
);

    // A stalled result item keeps its slot, status, count and head slot.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_slot)
            && $stable(i_status) && $stable(i_count) && $stable(i_head_slot),
        "result item changed while stalled")

    // Nothing is offered in the cycle after reset.
    `ASSERT_CLK_NR(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid,
        "result valid right after reset")

    // A refused item reports no slot.
    `ASSERT_CLK(a_err_slot, i_clk, i_rst_n,
        i_out_valid && i_status != illm_pkg::ST_OK |-> i_result_slot == '0,
        "failed operation reports a slot")

    // An empty list reports zero count and zero ends.
    `ASSERT_CLK(a_empty_view, i_clk, i_rst_n,
        i_out_valid && i_is_empty |-> i_count == '0 && i_head_slot == '0
            && i_tail_slot == '0,
        "empty list shows entries")

endmodule

bind indexed_linked_list_manager illm_checker u_illm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_result_slot (o_out.result_slot),
    .i_status      (o_out.status),
    .i_head_slot   (o_out.head_slot),
    .i_tail_slot   (o_out.tail_slot),
    .i_count       (o_out.count),
    .i_is_empty    (o_out.is_empty)
);

// ===== sim/illm_checker.sv =====
// Checker for the linked list manager: tracks the list, predicts each result and compares.
`timescale 1ns / 100ps

module illm_tb_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    illm_in_if   i_in,
    illm_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int SLOTS = illm_pkg::SLOTS_DEF;
    // A link equal to the table size marks the end of a chain.
    localparam logic [illm_pkg::COUNT_FW-1:0] NIL_LINK = illm_pkg::COUNT_FW'(SLOTS);

    logic [illm_pkg::COUNT_FW-1:0] nxt_tab [SLOTS];
    logic [illm_pkg::COUNT_FW-1:0] prv_tab [SLOTS];
    logic [illm_pkg::COUNT_FW-1:0] free_top;
    logic [illm_pkg::SLOT_FW-1:0]  front;
    logic [illm_pkg::SLOT_FW-1:0]  back;
    logic [illm_pkg::COUNT_FW-1:0] live;

    illm_pkg::t_result pending_results[$];
    int                errors = 0;
    int                waiting = 0;

    assign o_fail_count = errors;
    assign o_pending    = waiting;

    function automatic bit in_table(logic [illm_pkg::COUNT_FW-1:0] x);
        return x < SLOTS;
    endfunction

    // Applies one operation to the tracked list and queues the result it must give.
    task automatic advance_list(input logic [illm_pkg::MODE_W-1:0] op,
                                input logic [illm_pkg::SLOT_FW-1:0] at);
        illm_pkg::t_result             r;
        logic [illm_pkg::COUNT_FW-1:0] c;
        logic [illm_pkg::COUNT_FW-1:0] n;
        logic [illm_pkg::COUNT_FW-1:0] p;
        r = '0;
        r.status = illm_pkg::ST_OK;
        if (op == illm_pkg::MODE_AFTER || op == illm_pkg::MODE_BEFORE) begin
            if ({1'b0, at} > live) begin
                r.status = illm_pkg::ST_BAD;
            end else if (live >= SLOTS) begin
                r.status = illm_pkg::ST_FULL;
            end else begin
                // Recycled slots first, otherwise the next slot never handed out.
                if (in_table(free_top)) begin
                    c = free_top;
                    free_top = nxt_tab[c[illm_pkg::SLOT_FW-1:0]];
                end else begin
                    c = live;
                end
                nxt_tab[c[illm_pkg::SLOT_FW-1:0]] = NIL_LINK;
                prv_tab[c[illm_pkg::SLOT_FW-1:0]] = NIL_LINK;
                if (live == 0) begin
                    front = c[illm_pkg::SLOT_FW-1:0];
                    back  = c[illm_pkg::SLOT_FW-1:0];
                end else if (op == illm_pkg::MODE_AFTER) begin
                    n = nxt_tab[at];
                    prv_tab[c[illm_pkg::SLOT_FW-1:0]] = {1'b0, at};
                    if (in_table(n)) begin
                        prv_tab[n[illm_pkg::SLOT_FW-1:0]] = c;
                        nxt_tab[c[illm_pkg::SLOT_FW-1:0]] = n;
                    end
                    nxt_tab[at] = c;
                    if (!in_table(nxt_tab[c[illm_pkg::SLOT_FW-1:0]]))
                        back = c[illm_pkg::SLOT_FW-1:0];
                end else begin
                    p = prv_tab[at];
                    nxt_tab[c[illm_pkg::SLOT_FW-1:0]] = {1'b0, at};
                    if (in_table(p)) begin
                        prv_tab[c[illm_pkg::SLOT_FW-1:0]] = p;
                        nxt_tab[p[illm_pkg::SLOT_FW-1:0]] = c;
                    end
                    prv_tab[at] = c;
                    if (!in_table(prv_tab[c[illm_pkg::SLOT_FW-1:0]]))
                        front = c[illm_pkg::SLOT_FW-1:0];
                end
                live = live + 1'b1;
                r.result_slot = c[illm_pkg::SLOT_FW-1:0];
            end
        end else if (op == illm_pkg::MODE_REMOVE) begin
            if (live == 0) begin
                r.status = illm_pkg::ST_BAD;
            end else begin
                // A slot outside the list is unlinked all the same.
                n = nxt_tab[at];
                p = prv_tab[at];
                if (in_table(n)) begin
                    prv_tab[n[illm_pkg::SLOT_FW-1:0]] = p;
                    if (at == front) front = n[illm_pkg::SLOT_FW-1:0];
                end
                if (in_table(p)) begin
                    nxt_tab[p[illm_pkg::SLOT_FW-1:0]] = n;
                    if (at == back) back = p[illm_pkg::SLOT_FW-1:0];
                end
                nxt_tab[at] = free_top;
                free_top = {1'b0, at};
                live = live - 1'b1;
                r.result_slot = at;
            end
        end else begin
            r.status = illm_pkg::ST_BAD;
        end
        r.head_slot = (live == 0) ? '0 : front;
        r.tail_slot = (live == 0) ? '0 : back;
        r.count     = live;
        r.is_empty  = (live == 0);
        pending_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        illm_pkg::t_result want;
        illm_pkg::t_result seen;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                nxt_tab[s] = '0;
                prv_tab[s] = '0;
            end
            free_top = NIL_LINK;
            front = '0;
            back  = '0;
            live  = '0;
            pending_results.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                seen.result_slot = i_out.result_slot;
                seen.status      = i_out.status;
                seen.head_slot   = i_out.head_slot;
                seen.tail_slot   = i_out.tail_slot;
                seen.count       = i_out.count;
                seen.is_empty    = i_out.is_empty;
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result item with none expected: slot=%0d st=%0d", $time,
                                 seen.result_slot, seen.status);
                end else begin
                    want = pending_results.pop_front();
                    if (seen.result_slot !== want.result_slot || seen.status !== want.status ||
                        seen.head_slot !== want.head_slot || seen.tail_slot !== want.tail_slot ||
                        seen.count !== want.count || seen.is_empty !== want.is_empty) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: mismatch exp slot=%0d st=%0d hd=%0d tl=%0d n=%0d e=%0d",
                                     $time, want.result_slot, want.status, want.head_slot,
                                     want.tail_slot, want.count, want.is_empty);
                            $display("    got slot=%0d st=%0d hd=%0d tl=%0d n=%0d e=%0d",
                                     seen.result_slot, seen.status, seen.head_slot,
                                     seen.tail_slot, seen.count, seen.is_empty);
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready) advance_list(i_in.mode, i_in.slot);
        end
        waiting = pending_results.size();
    end

endmodule

// ===== sim/tb_indexed_linked_list_manager.sv =====
// Testbench top for the linked list manager: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_indexed_linked_list_manager;

    localparam logic [illm_pkg::MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 830;

    logic i_clk;
    logic i_rst_n;
    logic rx_ready = 1'b0;

    illm_in_if  in_ch ();
    illm_out_if out_ch ();

    int fail_count;
    int pending;

    indexed_linked_list_manager dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    illm_tb_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    assign out_ch.ready = rx_ready;

    // Slots the list is known to hold, as far as returned results tell.
    logic [illm_pkg::SLOTS_DEF-1:0] live_map = '0;
    logic [illm_pkg::MODE_W-1:0]    issued_ops[$];
    bit                             calm = 1'b0;
    bit                             long_hold_req = 1'b0;
    bit                             long_hold_done = 1'b0;
    int                             tx_gap_pct = 15;
    int                             rx_stall_pct = 15;
    int                             hold_left = 0;
    int                             cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off that backs the block up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rx_ready  <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_left <= 149;
            rx_ready  <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
            hold_left <= $urandom_range(0, 12);
            rx_ready  <= 1'b0;
        end else begin
            rx_ready <= 1'b1;
        end
    end

    // Follows returned results so that well-formed items can aim at live slots.
    always @(posedge i_clk) begin
        logic [illm_pkg::MODE_W-1:0] op;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready && issued_ops.size() != 0) begin
                op = issued_ops.pop_front();
                if (out_ch.status == illm_pkg::ST_OK && op != illm_pkg::MODE_REMOVE)
                    live_map[out_ch.result_slot] = 1'b1;
            end
            if (in_ch.valid && in_ch.ready) issued_ops.push_back(in_ch.mode);
        end
    end

    function automatic logic [illm_pkg::SLOT_FW-1:0] pick_live();
        int base;
        base = $urandom_range(0, illm_pkg::SLOTS_DEF - 1);
        for (int k = 0; k < illm_pkg::SLOTS_DEF; k++) begin
            if (live_map[(base + k) % illm_pkg::SLOTS_DEF])
                return illm_pkg::SLOT_FW'((base + k) % illm_pkg::SLOTS_DEF);
        end
        return '0;
    endfunction

    task automatic send_op(input logic [illm_pkg::MODE_W-1:0] op,
                           input logic [illm_pkg::SLOT_FW-1:0] at);
        if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= op;
        in_ch.slot  <= at;
        if (op == illm_pkg::MODE_REMOVE) live_map[at] = 1'b0;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    initial begin
        logic [illm_pkg::MODE_W-1:0]  op;
        logic [illm_pkg::SLOT_FW-1:0] at;
        bit                           filling;
        int                           roll;
        int                           fill_est;
        filling = 1'b1;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.mode  = illm_pkg::MODE_AFTER;
        in_ch.slot  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty-list corner cases, then a fill that writes every table entry before any
        // item can read one.
        send_op(illm_pkg::MODE_REMOVE, 4'd5);
        send_op(MODE_NONE, 4'd15);
        send_op(illm_pkg::MODE_AFTER, 4'd3);
        send_op(illm_pkg::MODE_BEFORE, 4'd0);
        for (int k = 1; k < illm_pkg::SLOTS_DEF; k++) begin
            if (k == 2) send_op(illm_pkg::MODE_AFTER, 4'd15);
            send_op(k[0] ? illm_pkg::MODE_AFTER : illm_pkg::MODE_BEFORE,
                    illm_pkg::SLOT_FW'($urandom_range(0, k - 1)));
        end
        send_op(illm_pkg::MODE_AFTER, 4'd15);
        send_op(illm_pkg::MODE_REMOVE, 4'd0);
        send_op(illm_pkg::MODE_REMOVE, 4'd15);
        send_op(illm_pkg::MODE_REMOVE, 4'd7);
        send_op(illm_pkg::MODE_BEFORE, 4'd3);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 64 == 0) begin
                roll = $urandom_range(0, 2);
                tx_gap_pct = (roll == 0) ? 0 : (roll == 1) ? 10 : 35;
                roll = $urandom_range(0, 2);
                rx_stall_pct = (roll == 0) ? 0 : (roll == 1) ? 10 : 35;
            end
            if (k == 250) long_hold_req = 1'b1;
            if (k == 500) begin
                // Let the block drain completely before going on.
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            if (k == RANDOM_ITEMS - 60) calm = 1'b1;

            if (k % 48 == 0) filling = ($urandom_range(0, 1) == 1);
            fill_est = $countones(live_map);
            if (fill_est == illm_pkg::SLOTS_DEF && $urandom_range(0, 1) == 0) filling = 1'b0;
            else if (fill_est == 0 && $urandom_range(0, 1) == 0) filling = 1'b1;

            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                op = MODE_NONE;
                at = illm_pkg::SLOT_FW'($urandom_range(0, illm_pkg::SLOTS_DEF - 1));
            end else if (roll < 5) begin
                // May hit a slot outside the list and leave the links inconsistent.
                op = illm_pkg::MODE_REMOVE;
                at = illm_pkg::SLOT_FW'($urandom_range(0, illm_pkg::SLOTS_DEF - 1));
            end else if (roll < 10) begin
                op = $urandom_range(0, 1) ? illm_pkg::MODE_AFTER : illm_pkg::MODE_BEFORE;
                at = illm_pkg::SLOT_FW'($urandom_range(0, illm_pkg::SLOTS_DEF - 1));
            end else if ($urandom_range(0, 99) < (filling ? 75 : 25)) begin
                op = $urandom_range(0, 1) ? illm_pkg::MODE_AFTER : illm_pkg::MODE_BEFORE;
                at = pick_live();
            end else begin
                op = illm_pkg::MODE_REMOVE;
                at = pick_live();
            end
            send_op(op, at);
        end
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/illm_pkg.sv
design/illm_if.sv
design/illm_update.sv
design/indexed_linked_list_manager.sv
design/illm_checker.sv
sim/illm_checker.sv
sim/tb_indexed_linked_list_manager.sv
